### src/plr_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared widths, request and status codes, and the command bundle that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package plr_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned CNT_OUT_W    = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_WRITE  = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Update command seen by every cell in the same cycle.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     wr;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

### src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with insert, delete, write and read
// by position, built as a row of storage cells that shift in parallel.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------
//  request | in_valid_i / in_ready_o | action_i, position_i, value_i
//  result  | out_valid_o / out_ready_i | data_o, status_o, count_o
//
// Each request transaction is served in the cycle in which it is accepted:
// the status is decided from the entry count, every cell updates at the same
// edge, and the result is captured in the output register at that edge, so
// it is offered on the result channel from the next cycle.
// A new request is taken whenever the output register is empty or is being
// emptied in the same cycle, so the sustained rate is one transaction per
// cycle; a stalled result transaction holds further requests back.
// Reset clears the entry count and the output valid flag; the cell contents
// are left as they are, since no position at or above the count is read.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned Capacity = plr_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic [plr_pkg::POS_W-1:0]          position_i,
  input  logic signed [plr_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [plr_pkg::DATA_W-1:0]  data_o,
  output logic [1:0]                         status_o,
  output logic [plr_pkg::CNT_OUT_W-1:0]      count_o
);

  // The count must be able to hold the capacity itself.
  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic                              accept;
  logic [CntW-1:0]                   cnt_d, cnt_q;
  logic [31:0]                       pos32, cnt32;
  plr_pkg::status_e                  status_d;
  plr_pkg::action_e                  act;
  plr_pkg::cell_cmd_t                cmd;
  logic signed [plr_pkg::DATA_W-1:0] data_d;

  logic                              out_valid_q;
  logic signed [plr_pkg::DATA_W-1:0] data_q;
  plr_pkg::status_e                  status_q;
  logic [plr_pkg::CNT_OUT_W-1:0]     count_q;

  logic signed [plr_pkg::DATA_W-1:0] entry [Capacity];
  logic signed [plr_pkg::DATA_W-1:0] rd_chain [Capacity+1];

  // The output register parts the two sides: a request is taken whenever
  // the held result is absent or leaves in this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign act   = plr_pkg::action_e'(action_i);
  assign pos32 = 32'(position_i);
  assign cnt32 = 32'(cnt_q);

  // Range and capacity checks decide the status before anything moves.
  always_comb begin
    status_d = plr_pkg::ST_DONE;
    if (act == plr_pkg::ACT_INSERT) begin
      if (pos32 > cnt32) begin
        status_d = plr_pkg::ST_RANGE;
      end else if (cnt32 >= Capacity) begin
        status_d = plr_pkg::ST_FULL;
      end
    end else if (pos32 >= cnt32 || pos32 >= Capacity) begin
      status_d = plr_pkg::ST_RANGE;
    end
  end

  // Only a successful transaction reaches the cells.
  always_comb begin
    cmd       = '0;
    cmd.pos   = position_i;
    cmd.value = value_i;
    if (accept && status_d == plr_pkg::ST_DONE) begin
      unique case (act)
        plr_pkg::ACT_INSERT: cmd.ins = 1'b1;
        plr_pkg::ACT_DELETE: cmd.del = 1'b1;
        plr_pkg::ACT_WRITE:  cmd.wr  = 1'b1;
        default:             ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd.del) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Read and delete return the addressed entry as it stood before the
  // update; everything else returns zero.
  always_comb begin
    data_d = '0;
    if (status_d == plr_pkg::ST_DONE &&
        (act == plr_pkg::ACT_DELETE || act == plr_pkg::ACT_READ)) begin
      data_d = rd_chain[Capacity];
    end
  end

  // Row of cells: each takes from its lower neighbour on insert and from its
  // upper neighbour on delete. The read chain runs through the same row.
  assign rd_chain[0] = '0;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [plr_pkg::DATA_W-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = entry[i+1];
    end

    plr_cell #(
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .rd_i    (rd_chain[i]),
      .entry_o (entry[i]),
      .rd_o    (rd_chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q   <= data_d;
      status_q <= status_d;
      count_q  <= plr_pkg::CNT_OUT_W'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

endmodule

### src/plr_cell.sv
// ----------------------------------------------------------------------------
// Positional list storage cell
// Holds one list entry, shifts from its neighbours on insert or delete and
// adds its entry to the read chain when the addressed position is its own.
// ----------------------------------------------------------------------------
module plr_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                             clk_i,
  input  plr_pkg::cell_cmd_t               cmd_i,
  input  logic signed [plr_pkg::DATA_W-1:0] lower_i,
  input  logic signed [plr_pkg::DATA_W-1:0] upper_i,
  input  logic signed [plr_pkg::DATA_W-1:0] rd_i,
  output logic signed [plr_pkg::DATA_W-1:0] entry_o,
  output logic signed [plr_pkg::DATA_W-1:0] rd_o
);

  logic signed [plr_pkg::DATA_W-1:0] entry_d, entry_q;
  logic                              hit, above;

  assign hit   = (32'(cmd_i.pos) == Index);
  assign above = (32'(cmd_i.pos) < Index);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (above) begin
        entry_d = lower_i;
      end else if (hit) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (hit || above) begin
        entry_d = upper_i;
      end
    end else if (cmd_i.wr && hit) begin
      entry_d = cmd_i.value;
    end
  end

  // Entry payload carries no reset: positions at or above the count are
  // never read.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_i | (hit ? entry_q : '0);

endmodule

### src/plr_checker.sv
// ----------------------------------------------------------------------------
// Positional list engine port checker
// Watches the ports of the top level and flags result transactions that
// break the handshake or contradict the request that caused them.
// ----------------------------------------------------------------------------
module plr_checker #(
  parameter int unsigned Capacity = plr_pkg::CAPACITY_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         action_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [plr_pkg::DATA_W-1:0]  data_o,
  input logic [1:0]                         status_o,
  input logic [plr_pkg::CNT_OUT_W-1:0]      count_o
);

  // A result transaction holds steady until it is taken.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_o) &&
      $stable(status_o) && $stable(count_o))
    else $error("result changed while stalled");

  // Every accepted request produces a result in the next cycle.
  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

  // Only an insert can report a full list.
  a_full_on_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i != plr_pkg::ACT_INSERT
      |=> status_o != plr_pkg::ST_FULL)
    else $error("full status on a request that is not an insert");

  // Errors return no data.
  a_err_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != plr_pkg::ST_DONE |-> data_o == '0)
    else $error("error result carries data");

  // A full report comes only with the list at capacity.
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == plr_pkg::ST_FULL
      |-> count_o == plr_pkg::CNT_OUT_W'(Capacity))
    else $error("full status with list below capacity");

endmodule

bind positional_list_engine plr_checker #(
  .Capacity (Capacity)
) u_plr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_o      (data_o),
  .status_o    (status_o),
  .count_o     (count_o)
);
